/* hdl/hbe_pkg.sv */
// Shared constants and types for the table-driven Huffman byte encoder.
// Used by hbe_lookup, hbe_packer and huffman_byte_encoder_packer.
`timescale 1ns / 1ps

package hbe_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam int MAX_CODE_LEN = 32;
  // Stored lengths saturate at the smaller of MAX_CODE_LEN and the code field width
  localparam int LEN_CAP      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  // Pending bits (at most 7) followed by one code
  localparam int ACC_W        = LEN_CAP + 7;
  localparam int SHAMT_W      = $clog2(ACC_W + 1);

  // Item handed from the table lookup stage to the packer
  typedef struct packed {
    logic        flush;
    logic [31:0] code;
    logic [5:0]  len;
  } item_t;

endpackage

/* hdl/hbe_lookup.sv */
// Code/length table and lookup stage register.
// Depends on hbe_pkg.
`timescale 1ns / 1ps

module hbe_lookup (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_symbol,
  input  logic [31:0]   in_code,
  input  logic [5:0]    in_len,
  output logic          item_valid,
  input  logic          item_ready,
  output hbe_pkg::item_t item
);

  logic [31:0] code_mem [256];
  logic [5:0]  len_mem  [256];

  logic        take;
  logic        wr_en;
  logic        fwd;
  logic [5:0]  wr_len;
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_flush_r;
  logic [31:0] rd_code_r;
  logic [5:0]  rd_len_r;

  assign in_ready = !s1_valid_r || item_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    wr_en = 1'b0;
    fwd   = 1'b0;
    case (in_op)
      hbe_pkg::OP_LOAD:   wr_en = 1'b1;
      hbe_pkg::OP_ENCODE: fwd   = 1'b1;
      hbe_pkg::OP_FLUSH:  fwd   = 1'b1;
      default: begin
        wr_en = 1'b0;
        fwd   = 1'b0;
      end
    endcase
  end

  assign wr_len = (in_len > 6'(hbe_pkg::LEN_CAP)) ? 6'(hbe_pkg::LEN_CAP) : in_len;

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      code_mem[in_symbol] <= in_code;
      len_mem[in_symbol]  <= wr_len;
    end
  end

  // registered read; held while the packer is busy
  always_ff @(posedge clk) begin
    if (take) begin
      rd_code_r  <= code_mem[in_symbol];
      rd_len_r   <= len_mem[in_symbol];
      s1_flush_r <= (in_op == hbe_pkg::OP_FLUSH);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = fwd;
    end else if (item_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign item_valid = s1_valid_r;
  assign item.flush = s1_flush_r;
  assign item.code  = rd_code_r;
  assign item.len   = rd_len_r;

endmodule

/* hdl/hbe_packer.sv */
// Bit packer: merges a looked-up code with the pending bits and sends out
// up to four bytes, one per cycle while out_ready is high. Depends on hbe_pkg.
`timescale 1ns / 1ps

module hbe_packer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_ready,
  input  hbe_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic [3:0]     out_vbits,
  output logic           out_last
);

  localparam int AW = hbe_pkg::ACC_W;
  localparam int SW = hbe_pkg::SHAMT_W;

  logic [6:0]    pend_bits_r, pend_bits_nxt;
  logic [2:0]    pend_cnt_r, pend_cnt_nxt;
  logic [2:0]    rem_r;
  logic [1:0]    idx_r;
  logic [7:0]    byte_r [4];
  logic [3:0]    vb_r;

  logic          take;
  logic          out_take;
  logic [32:0]   mask;
  logic [AW-1:0] acc;
  logic [AW-1:0] aligned;
  logic [SW-1:0] total;
  logic [7:0]    cnt_mask;
  logic [2:0]    n_nxt;
  logic [3:0]    vb_nxt;
  logic [7:0]    bytes_nxt [4];

  assign out_valid  = (rem_r != 3'd0);
  assign out_take   = out_valid && out_ready;
  assign item_ready = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready);
  assign take       = item_valid && item_ready;

  always_comb begin
    mask     = (33'd1 << item.len) - 33'd1;
    acc      = (AW'(pend_bits_r) << item.len) | AW'(item.code & mask[31:0]);
    total    = SW'(pend_cnt_r) + SW'(item.len);
    // first code bit lands in the top bit
    aligned  = acc << (SW'(AW) - total);
    cnt_mask = (8'd1 << total[2:0]) - 8'd1;
    for (int k = 0; k < 4; k++) begin
      bytes_nxt[k] = aligned[AW-1-8*k -: 8];
    end
    vb_nxt        = 4'd8;
    n_nxt         = 3'(total >> 3);
    pend_cnt_nxt  = total[2:0];
    pend_bits_nxt = acc[6:0] & cnt_mask[6:0];
    if (item.flush) begin
      bytes_nxt[0]  = {1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r});
      vb_nxt        = {1'b0, pend_cnt_r};
      n_nxt         = (pend_cnt_r != 3'd0) ? 3'd1 : 3'd0;
      pend_cnt_nxt  = 3'd0;
      pend_bits_nxt = 7'd0;
    end else if (item.len == 6'd0) begin
      n_nxt         = 3'd0;
      pend_cnt_nxt  = pend_cnt_r;
      pend_bits_nxt = pend_bits_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= 7'd0;
      pend_cnt_r  <= 3'd0;
      rem_r       <= 3'd0;
      idx_r       <= 2'd0;
    end else if (take) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      rem_r       <= n_nxt;
      idx_r       <= 2'd0;
    end else if (out_take) begin
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < 4; k++) begin
        byte_r[k] <= bytes_nxt[k];
      end
      vb_r <= vb_nxt;
    end
  end

  assign out_byte  = byte_r[idx_r];
  assign out_vbits = vb_r;
  assign out_last  = (rem_r == 3'd1);

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("burst count above four");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !take) |=> (rem_r == $past(rem_r) && idx_r == $past(idx_r)))
    else $error("burst moved while stalled");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.flush) |=> (pend_cnt_r == 3'd0 && pend_bits_r == 7'd0))
    else $error("pending bits left after flush");

  a_ready_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    item_ready |-> (rem_r <= 3'd1))
    else $error("new item taken mid-burst");

endmodule

/* hdl/huffman_byte_encoder_packer.sv */
// Top level of the table-driven Huffman encoder with MSB-first byte packer.
// Depends on hbe_pkg, hbe_lookup and hbe_packer.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one item per handshake. in_tuser selects load (0), encode (1)
//           or flush (2); code 3 is dropped. Load writes code and length for
//           one symbol; encode appends that symbol's code to the bit stream;
//           flush sends out any partial byte, zero padded in its low bits.
//   out_* : one packed byte per handshake, first code bit in bit 7, with the
//           count of valid bits; out_tlast marks the last byte of an item.
//   The first byte of an item passes through the table read register and
//   then the byte buffer before it is offered on out_*.
//   An encode item yields 0 to 4 bytes, sent one byte per cycle while
//   out_tready is high. Loads and items that yield one byte or none go at
//   one per cycle while the output does not stall.
//   Reset clears the pending bits and all handshake state; the table is not
//   cleared and a symbol must be loaded before it is encoded.
//   When out_tready is low the byte buffer holds, the lookup register fills
//   and in_tready then drops until the output drains.

module huffman_byte_encoder_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40], 0
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte[7:0], valid_bits[11:8], 0
  output logic        out_tlast
);

  logic           item_valid;
  logic           item_ready;
  hbe_pkg::item_t item;
  logic [7:0]     out_byte;
  logic [3:0]     out_vbits;

  hbe_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_symbol  (in_tdata[7:0]),
    .in_code    (in_tdata[39:8]),
    .in_len     (in_tdata[45:40]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  hbe_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_byte),
    .out_vbits  (out_vbits),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'd0, out_vbits, out_byte};

endmodule
